// ===== hdl/olds_pkg.sv =====
// olds_pkg: shared types, constants and ring arithmetic for the ordered list store
// used by olds_seq and ordered_list_deque_store; depends on nothing else
package olds_pkg;

   // list capacity and derived widths
   localparam int DEPTH   = 16;
   localparam int IDX_W   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W   = $clog2(DEPTH + 1);
   localparam int SUM_W   = CNT_W + 1;
   localparam int VALUE_W = 32;
   localparam int COUNT_W = 5;

   localparam logic [CNT_W-1:0] DEPTH_CNT = CNT_W'(DEPTH);
   localparam logic [IDX_W-1:0] LAST_IDX  = IDX_W'(DEPTH - 1);

   typedef enum logic [1:0] {
      OP_INS_FRONT = 2'd0,
      OP_INS_BACK  = 2'd1,
      OP_SEARCH    = 2'd2,
      OP_DELETE    = 2'd3
   } op_kind_type;

   typedef enum logic [1:0] {
      ST_OK        = 2'd0,
      ST_NOT_FOUND = 2'd1,
      ST_EMPTY     = 2'd2,
      ST_FULL      = 2'd3
   } status_code_type;

   typedef enum logic [1:0] {
      SEQ_IDLE,
      SEQ_SCAN,
      SEQ_SHIFT,
      SEQ_FINISH
   } seq_state_type;

   typedef struct packed {
      op_kind_type               req_type;
      logic signed [VALUE_W-1:0] item_value;
   } olds_req_type;

   typedef struct packed {
      status_code_type      status;
      logic                 found;
      logic [COUNT_W-1:0]   entry_count;
   } olds_rsp_type;

   // ring slot of list position off, taken modulo DEPTH (off never exceeds DEPTH)
   function automatic logic [IDX_W-1:0] ring_pos(input logic [IDX_W-1:0] head,
                                                 input logic [CNT_W-1:0] off);
      logic [SUM_W-1:0] sum;
      sum = {{(SUM_W - IDX_W){1'b0}}, head} + {1'b0, off};
      if (sum >= SUM_W'(DEPTH)) begin
         sum = sum - SUM_W'(DEPTH);
      end
      return sum[IDX_W-1:0];
   endfunction

endpackage

// ===== hdl/olds_seq.sv =====
// olds_seq: request sequencer with the value memory and the shared compare unit
// depends on olds_pkg
module olds_seq (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  olds_pkg::olds_req_type req_data,
   output logic                  res_valid,
   input  logic                  res_ready,
   output olds_pkg::olds_rsp_type res_data
);

   localparam int IW = olds_pkg::IDX_W;
   localparam int CW = olds_pkg::CNT_W;
   localparam int VW = olds_pkg::VALUE_W;
   localparam int RW = olds_pkg::COUNT_W;

   olds_pkg::seq_state_type  state_ff, state_in;
   logic [IW-1:0]            head_ff, head_in;
   logic [CW-1:0]            len_ff, len_in;
   olds_pkg::op_kind_type    op_ff, op_in;
   logic [VW-1:0]            val_ff, val_in;
   logic [CW-1:0]            issue_ff, issue_in;
   logic                     cmp_vld_ff, cmp_vld_in;
   logic [CW-1:0]            cmp_pos_ff, cmp_pos_in;
   logic [CW-1:0]            sh_rd_ff, sh_rd_in;
   logic                     wr_vld_ff, wr_vld_in;
   logic [CW-1:0]            wr_pos_ff, wr_pos_in;
   olds_pkg::olds_rsp_type   res_ff, res_in;

   logic [VW-1:0]            mem [olds_pkg::DEPTH];
   logic [VW-1:0]            rdata_ff;
   logic                     we;
   logic [IW-1:0]            waddr;
   logic [IW-1:0]            raddr;
   logic [VW-1:0]            wdata;
   logic                     hit;

   // value memory: one write port, one registered read port
   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata_ff <= mem[raddr];
   end

   // shared equality compare
   assign hit = (rdata_ff == val_ff);

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= olds_pkg::SEQ_IDLE;
         head_ff    <= '0;
         len_ff     <= '0;
         cmp_vld_ff <= 1'b0;
         wr_vld_ff  <= 1'b0;
      end else begin
         state_ff   <= state_in;
         head_ff    <= head_in;
         len_ff     <= len_in;
         cmp_vld_ff <= cmp_vld_in;
         wr_vld_ff  <= wr_vld_in;
      end
   end

   // payload and position registers
   always_ff @(posedge clock) begin
      op_ff      <= op_in;
      val_ff     <= val_in;
      issue_ff   <= issue_in;
      cmp_pos_ff <= cmp_pos_in;
      sh_rd_ff   <= sh_rd_in;
      wr_pos_ff  <= wr_pos_in;
      res_ff     <= res_in;
   end

   // next state and datapath control
   always_comb begin
      state_in   = state_ff;
      head_in    = head_ff;
      len_in     = len_ff;
      op_in      = op_ff;
      val_in     = val_ff;
      issue_in   = issue_ff;
      cmp_vld_in = 1'b0;
      cmp_pos_in = cmp_pos_ff;
      sh_rd_in   = sh_rd_ff;
      wr_vld_in  = 1'b0;
      wr_pos_in  = wr_pos_ff;
      res_in     = res_ff;
      we         = 1'b0;
      waddr      = head_ff;
      wdata      = req_data.item_value;
      raddr      = head_ff;
      req_ready  = 1'b0;
      res_valid  = 1'b0;

      case (state_ff)
         olds_pkg::SEQ_IDLE: begin
            req_ready          = 1'b1;
            res_in.found       = 1'b0;
            res_in.status      = olds_pkg::ST_OK;
            res_in.entry_count = RW'(len_ff);
            if (req_valid) begin
               op_in    = req_data.req_type;
               val_in   = req_data.item_value;
               issue_in = '0;
               case (req_data.req_type)
                  olds_pkg::OP_INS_FRONT, olds_pkg::OP_INS_BACK: begin
                     state_in = olds_pkg::SEQ_FINISH;
                     if (len_ff == olds_pkg::DEPTH_CNT) begin
                        res_in.status = olds_pkg::ST_FULL;
                     end else begin
                        we     = 1'b1;
                        len_in = len_ff + 1'b1;
                        res_in.entry_count = RW'(len_ff + 1'b1);
                        if (req_data.req_type == olds_pkg::OP_INS_FRONT) begin
                           head_in = (head_ff == '0) ? olds_pkg::LAST_IDX
                                                     : head_ff - 1'b1;
                           waddr   = head_in;
                        end else begin
                           waddr = olds_pkg::ring_pos(head_ff, len_ff);
                        end
                     end
                  end
                  default: begin
                     if (len_ff == '0) begin
                        res_in.status = olds_pkg::ST_EMPTY;
                        state_in      = olds_pkg::SEQ_FINISH;
                     end else begin
                        state_in = olds_pkg::SEQ_SCAN;
                     end
                  end
               endcase
            end
         end

         // walk the list from the front, one read issued and one compare a cycle
         olds_pkg::SEQ_SCAN: begin
            raddr = olds_pkg::ring_pos(head_ff, issue_ff);
            if (issue_ff < len_ff) begin
               issue_in   = issue_ff + 1'b1;
               cmp_vld_in = 1'b1;
               cmp_pos_in = issue_ff;
            end
            if (cmp_vld_ff) begin
               if (hit) begin
                  cmp_vld_in = 1'b0;
                  if (op_ff == olds_pkg::OP_SEARCH) begin
                     res_in.found  = 1'b1;
                     res_in.status = olds_pkg::ST_OK;
                     state_in      = olds_pkg::SEQ_FINISH;
                  end else begin
                     sh_rd_in = cmp_pos_ff + 1'b1;
                     state_in = olds_pkg::SEQ_SHIFT;
                  end
               end else if (cmp_pos_ff == len_ff - 1'b1) begin
                  cmp_vld_in    = 1'b0;
                  res_in.status = olds_pkg::ST_NOT_FOUND;
                  state_in      = olds_pkg::SEQ_FINISH;
               end
            end
         end

         // close the gap: read position j, write it to position j-1 next cycle
         olds_pkg::SEQ_SHIFT: begin
            raddr = olds_pkg::ring_pos(head_ff, sh_rd_ff);
            if (sh_rd_ff < len_ff) begin
               sh_rd_in  = sh_rd_ff + 1'b1;
               wr_vld_in = 1'b1;
               wr_pos_in = sh_rd_ff - 1'b1;
            end
            if (wr_vld_ff) begin
               we    = 1'b1;
               waddr = olds_pkg::ring_pos(head_ff, wr_pos_ff);
               wdata = rdata_ff;
            end
            if (sh_rd_ff >= len_ff && !wr_vld_ff) begin
               len_in             = len_ff - 1'b1;
               res_in.found       = 1'b1;
               res_in.status      = olds_pkg::ST_OK;
               res_in.entry_count = RW'(len_ff - 1'b1);
               state_in           = olds_pkg::SEQ_FINISH;
            end
         end

         olds_pkg::SEQ_FINISH: begin
            res_valid = 1'b1;
            if (res_ready) begin
               state_in = olds_pkg::SEQ_IDLE;
            end
         end

         default: begin
            state_in = olds_pkg::SEQ_IDLE;
         end
      endcase
   end

   assign res_data = res_ff;

   // length never passes capacity
   a_len_bound: assert property (@(posedge clock) disable iff (reset)
      len_ff <= olds_pkg::DEPTH_CNT)
      else $error("list length above capacity");

   // the scan never changes the length or writes the memory
   a_scan_quiet: assert property (@(posedge clock) disable iff (reset)
      (state_ff == olds_pkg::SEQ_SCAN) |=> (len_ff == $past(len_ff)) && !$past(we))
      else $error("scan modified list state");

   // compares only look at live positions
   a_cmp_live: assert property (@(posedge clock) disable iff (reset)
      cmp_vld_ff |-> (cmp_pos_ff < len_ff))
      else $error("compare beyond list end");

   // shift writes only land on live positions
   a_shift_live: assert property (@(posedge clock) disable iff (reset)
      wr_vld_ff |-> (state_ff == olds_pkg::SEQ_SHIFT) && (wr_pos_ff < len_ff))
      else $error("shift write out of range");

endmodule

// ===== hdl/ordered_list_deque_store.sv =====
// an insert, or a search or delete on an empty list, needs no walk; a search walks the list
// from the front up to the match or the end; a delete walks to the match, then moves each
// later entry down one place (on a miss it ends after the walk)
// throughput: one request at a time; the walk handles one entry a cycle
// reset: synchronous, empties the list (head 0, length 0); memory is not cleared
// ordered_list_deque_store: top level with the response register; uses olds_seq, olds_pkg
module ordered_list_deque_store (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  olds_pkg::olds_req_type req_data,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output olds_pkg::olds_rsp_type rsp_data
);

   logic                   res_valid;
   logic                   res_ready;
   olds_pkg::olds_rsp_type res_data;
   logic                   rsp_valid_ff, rsp_valid_in;
   olds_pkg::olds_rsp_type rsp_data_ff, rsp_data_in;

   olds_seq u_seq (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .res_valid (res_valid),
      .res_ready (res_ready),
      .res_data  (res_data)
   );

   // response register: takes a new beat when empty or being drained
   assign res_ready = !rsp_valid_ff || rsp_ready;

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      if (res_ready) begin
         rsp_valid_in = res_valid;
         if (res_valid) begin
            rsp_data_in = res_data;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule
